// ===== hw/rtl/mr_pkg.sv =====
// Package for the Miller-Rabin prime test block.
// Holds the operand width, the base table and the mod-3 helper; no dependencies.
package mr_pkg;
  localparam int NUMBER_BITS = 63;
  localparam int NB = NUMBER_BITS;
  localparam int SW = $clog2(NB + 1);
  localparam int NUM_BASES = 7;

  function automatic logic [30:0] base_of(input logic [2:0] k);
    logic [30:0] b;
    case (k)
      3'd0: b = 31'd2;
      3'd1: b = 31'd325;
      3'd2: b = 31'd9375;
      3'd3: b = 31'd28178;
      3'd4: b = 31'd450775;
      3'd5: b = 31'd9780504;
      default: b = 31'd1795265022;
    endcase
    return b;
  endfunction

  // Residue mod 3 of a 2-bit digit sum, folded from the word's 2-bit digits.
  function automatic logic [1:0] mod3_step(input logic [1:0] r, input logic [1:0] digit);
    logic [2:0] t;
    t = {1'b0, r} + {1'b0, digit};
    if (t >= 3'd3) t = t - 3'd3;
    return t[1:0];
  endfunction
endpackage

// ===== hw/rtl/mr_mulmod.sv =====
// Shift-and-add modular multiplier, one bit of y per cycle.
// Uses mr_pkg for the operand width.
module mr_mulmod import mr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NB-1:0] x,
  input  logic [NB-1:0] y,
  input  logic [NB-1:0] n,
  output logic          done,
  output logic [NB-1:0] prod
);
  logic          busy;
  logic [SW-1:0] bitcnt;
  logic [NB-1:0] ysh;
  logic [NB:0]   dbl, dbl_red, sum;
  logic [NB-1:0] acc_next;

  always_comb begin
    dbl = {prod, 1'b0};
    dbl_red = (dbl >= {1'b0, n}) ? dbl - {1'b0, n} : dbl;
    sum = dbl_red + {1'b0, x};
    if (sum >= {1'b0, n}) sum = sum - {1'b0, n};
    acc_next = ysh[NB-1] ? sum[NB-1:0] : dbl_red[NB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        prod <= '0;
        ysh <= y;
        bitcnt <= SW'(NB);
      end else if (busy) begin
        prod <= acc_next;
        ysh <= {ysh[NB-2:0], 1'b0};
        bitcnt <= bitcnt - 1'b1;
        if (bitcnt == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/miller_rabin_prime_test.sv =====
// Top level of the Miller-Rabin prime test: sequencer around one mulmod unit.
// Depends on mr_pkg and mr_mulmod.
//
//  channel | signals                | beat
//  in      | valid, stall, number   | one 63-bit integer
//  out     | out_valid, out_stall   | is_prime for that integer
//
// One beat first folds the residue mod 3, which settles the trivial cases; otherwise
// it tests up to 7 bases: every modular product, the base reduction included,
// runs on the shared multiplier, and a base needs at most about 125 of them.
// Reset is synchronous and clears the sequencer. The input is stalled while a
// test runs; the result register holds until the output beat is taken.
module miller_rabin_prime_test import mr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid,
  output logic          stall,
  input  logic [NB-1:0] number,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          is_prime
);
  localparam logic [3:0] S_IDLE = 4'd0, S_MOD3 = 4'd1, S_SPLIT = 4'd2, S_BASE = 4'd3,
                         S_BRED = 4'd4, S_PBIT = 4'd5, S_PMUL = 4'd6, S_PSQ = 4'd7,
                         S_CHK = 4'd8, S_SQ = 4'd9, S_SQW = 4'd10, S_DONE = 4'd11;
  localparam int DIG = (NB + 1) / 2;

  logic [3:0]    state;
  logic [NB-1:0] n, d, e, x, p;
  logic [SW-1:0] s, r, cnt;
  logic [1:0]    m3;
  logic [2:0]    k;
  logic          res;
  logic          mstart, mdone;
  logic [NB-1:0] ma, mb, mprod;
  logic [NB-1:0] nm1;

  assign nm1 = n - 1'b1;
  assign stall = (state != S_IDLE) || out_valid;

  mr_mulmod u_mul (.clk(clk), .rst(rst), .start(mstart), .x(ma), .y(mb), .n(n),
                   .done(mdone), .prod(mprod));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      mstart <= 1'b0;
    end else begin
      mstart <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (valid && !stall) begin
          n <= number;
          e <= number;
          m3 <= 2'd0;
          cnt <= '0;
          state <= S_MOD3;
        end
        S_MOD3: begin
          // Two bits a cycle: 4 = 1 mod 3, so the digit sum gives the residue.
          m3 <= mod3_step(m3, (e[1:0] == 2'd3) ? 2'd0 : e[1:0]);
          e <= e >> 2;
          cnt <= cnt + 1'b1;
          if (cnt == SW'(DIG - 1)) begin
            if (n < NB'(4)) begin
              res <= (n >= NB'(2));
              state <= S_DONE;
            end else if (!n[0] || mod3_step(m3, (e[1:0] == 2'd3) ? 2'd0 : e[1:0]) == 2'd0) begin
              res <= 1'b0;
              state <= S_DONE;
            end else begin
              d <= nm1;
              s <= '0;
              state <= S_SPLIT;
            end
          end
        end
        S_SPLIT: if (!d[0]) begin
          d <= d >> 1;
          s <= s + 1'b1;
        end else begin
          k <= 3'd0;
          res <= 1'b1;
          state <= S_BASE;
        end
        S_BASE: begin
          // With x = 1 the multiplier returns the base reduced mod n.
          ma <= NB'(1);
          mb <= NB'(base_of(k));
          mstart <= 1'b1;
          state <= S_BRED;
        end
        S_BRED: if (mdone) begin
          if (mprod == '0) begin
            if (k == 3'(NUM_BASES - 1)) state <= S_DONE;
            else begin
              k <= k + 1'b1;
              state <= S_BASE;
            end
          end else begin
            x <= mprod;
            e <= d;
            p <= NB'(1);
            state <= S_PBIT;
          end
        end
        S_PBIT: if (e == '0) begin
          state <= S_CHK;
        end else if (e[0]) begin
          ma <= p; mb <= x; mstart <= 1'b1;
          state <= S_PMUL;
        end else begin
          ma <= x; mb <= x; mstart <= 1'b1;
          state <= S_PSQ;
        end
        S_PMUL: if (mdone) begin
          p <= mprod;
          ma <= x; mb <= x; mstart <= 1'b1;
          state <= S_PSQ;
        end
        S_PSQ: if (mdone) begin
          x <= mprod;
          e <= e >> 1;
          state <= S_PBIT;
        end
        S_CHK: if (p == NB'(1) || p == nm1) begin
          if (k == 3'(NUM_BASES - 1)) state <= S_DONE;
          else begin k <= k + 1'b1; state <= S_BASE; end
        end else begin
          r <= SW'(1);
          state <= S_SQ;
        end
        S_SQ: begin
          if (p == nm1) begin
            if (k == 3'(NUM_BASES - 1)) state <= S_DONE;
            else begin k <= k + 1'b1; state <= S_BASE; end
          end else if (r >= s) begin
            res <= 1'b0;
            state <= S_DONE;
          end else begin
            ma <= p; mb <= p; mstart <= 1'b1;
            state <= S_SQW;
          end
        end
        S_SQW: if (mdone) begin
          p <= mprod;
          r <= r + 1'b1;
          state <= S_SQ;
        end
        S_DONE: begin
          is_prime <= res;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== test/tb_miller_rabin_prime_test.sv =====
// Testbench for miller_rabin_prime_test: drives integers, checks is_prime beats against
// known answers or a behavioral strong-probable-prime predictor. Depends on mr_pkg and the RTL.
module tb_miller_rabin_prime_test import mr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic [NB-1:0] number = '0;
  logic out_stall = 1'b0;
  logic stall, out_valid, is_prime;

  logic expected_prime_q[$];
  int errors = 0;
  int send_idle_pct = 30;
  int recv_idle_pct = 63;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  typedef struct {
    logic [NB-1:0] value;
    bit            known;
    logic          answer;
  } dir_row_t;

  miller_rabin_prime_test u_dut (
    .clk(clk), .rst(rst), .valid(valid), .stall(stall), .number(number),
    .out_valid(out_valid), .out_stall(out_stall), .is_prime(is_prime)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] mulmod(input logic [63:0] x, input logic [63:0] y,
                                         input logic [63:0] n);
    logic [63:0] acc;
    acc = 0;
    for (int b = 63; b >= 0; b--) begin
      acc = acc + acc;
      if (acc >= n) acc = acc - n;
      if (y[b]) begin
        acc = acc + x;
        if (acc >= n) acc = acc - n;
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] powmod(input logic [63:0] x, input logic [63:0] e,
                                         input logic [63:0] n);
    logic [63:0] acc;
    acc = 1 % n;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, x, n);
      x = mulmod(x, x, n);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic primality(input logic [NB-1:0] v);
    logic [63:0] n, d, a, p;
    int s;
    bit ok;
    n = {{(64-NB){1'b0}}, v};
    if (n < 2 || n % 2 == 0 || n % 3 == 0) return (n == 2 || n == 3);
    d = n - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    for (int k = 0; k < NUM_BASES; k++) begin
      a = {33'd0, base_of(k[2:0])} % n;
      if (a == 0) continue;
      p = powmod(a, d, n);
      if (p == 1 || p == n - 1) continue;
      ok = 1'b0;
      for (int r = 1; r < s; r++) begin
        p = mulmod(p, p, n);
        if (p == n - 1) begin
          ok = 1'b1;
          break;
        end
      end
      if (!ok) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Sends one beat, idling beforehand at the current sender rate.
  task automatic send_number(input logic [NB-1:0] v, input logic answer);
    while ($urandom_range(99) < send_idle_pct) begin
      valid <= 1'b0;
      @(posedge clk);
    end
    valid  <= 1'b1;
    number <= v;
    expected_prime_q = {expected_prime_q, answer};
    @(posedge clk);
    while (stall) @(posedge clk);
  endtask

  function automatic logic [NB-1:0] rand_number();
    logic [NB-1:0] v;
    int kind;
    v = NB'({$urandom, $urandom});
    kind = $urandom_range(9);
    if (kind < 3) v = v >> $urandom_range(NB - 1);
    else if (kind < 5) v = NB'($urandom_range(1000));
    else if (kind < 8) v[0] = 1'b1;
    return v;
  endfunction

  // Receiver side: random stalls, long hold-off when requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off) out_stall <= 1'b1;
      else out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_prime_q.size() == 0) begin
        $display("%0t: unexpected result beat, is_prime=%0b", $time, is_prime);
        errors++;
      end else begin
        logic e;
        e = expected_prime_q.pop_front();
        if (e !== is_prime) begin
          $display("%0t: is_prime mismatch: expected %0b actual %0b", $time, e, is_prime);
          errors++;
        end
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    logic [NB-1:0] all_ones;
    all_ones = '1;
    rows = '{
      '{0, 1, 0}, '{1, 1, 0}, '{2, 1, 1}, '{3, 1, 1}, '{4, 1, 0}, '{9, 1, 0},
      '{5, 1, 1}, '{7, 1, 1}, '{25, 0, 0}, '{325, 1, 0}, '{13, 0, 0}, '{5, 0, 0},
      '{561, 0, 0}, '{63'd3215031751, 0, 0}, '{63'd1795265023, 0, 0},
      '{63'd9223372036854775783, 1, 1}, '{all_ones, 1, 0},
      '{all_ones - 1, 1, 0}, '{63'h5555555555555555, 0, 0},
      '{63'h2AAAAAAAAAAAAAAB, 0, 0}, '{63'd4611686018427387847, 0, 0},
      '{63'd3825123056546413051, 0, 0}, '{63'd1000000007, 0, 0}
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i])
      send_number(rows[i].value,
                  rows[i].known ? rows[i].answer : primality(rows[i].value));
    // Hold the receiver off while the sender keeps offering beats.
    hold_off = 1'b1;
    fork
      begin
        repeat (3) begin
          logic [NB-1:0] hv;
          hv = rand_number();
          send_number(hv, primality(hv));
        end
      end
      begin
        repeat (20000) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 63 : 0;
      recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 30 : 0;
      repeat (26) begin
        logic [NB-1:0] v;
        v = rand_number();
        send_number(v, primality(v));
      end
    end
    valid <= 1'b0;
    while (expected_prime_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #800ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
